FILE: rtl/core/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared widths, constants and the arctangent table of the sine PWM modulator.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int SUPPLY_W   = 16;  // supply register, mV
  localparam int CMD_W      = 16;  // q-axis command, mV
  localparam int ANG_IN_W   = 16;  // angle input field
  localparam int DUTY_OUT_W = 16;  // duty output field

  localparam int U2_W    = 18;     // doubled and clamped command (half-mV)
  localparam int TURN_W  = 32;     // angle as a 32-bit fraction of a turn
  localparam int CORD_W  = 34;     // CORDIC x/y datapath
  localparam int TRIG_W  = 32;     // sin/cos, Q2.30
  localparam int VOLT_W  = 40;     // phase voltages, half-mV scaled by 2^16
  localparam int FULL_W  = SUPPLY_W + 17;  // full scale = supply * 2^17

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [U2_W-1:0]   SQRT3_Q16       = 18'sd113512;

  typedef logic signed [VOLT_W-1:0] phase_volt_t;
  typedef phase_volt_t phase_vec_t [3];

  // arctangent of 2^-i as a fraction of a turn scaled by 2^32
  function automatic logic signed [TURN_W-1:0] atan_turn(input int idx);
    logic signed [TURN_W-1:0] val;
    case (idx)
      0:       val = 32'sd536870912;
      1:       val = 32'sd316933406;
      2:       val = 32'sd167458907;
      3:       val = 32'sd85004756;
      4:       val = 32'sd42667331;
      5:       val = 32'sd21354465;
      6:       val = 32'sd10679838;
      7:       val = 32'sd5340245;
      8:       val = 32'sd2670163;
      9:       val = 32'sd1335087;
      10:      val = 32'sd667544;
      11:      val = 32'sd333772;
      12:      val = 32'sd166886;
      13:      val = 32'sd83443;
      14:      val = 32'sd41722;
      15:      val = 32'sd20861;
      16:      val = 32'sd10430;
      17:      val = 32'sd5215;
      18:      val = 32'sd2608;
      19:      val = 32'sd1304;
      20:      val = 32'sd652;
      21:      val = 32'sd326;
      22:      val = 32'sd163;
      23:      val = 32'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/core/spm_cordic.sv
// ----------------------------------------------------------------------------
// spm_cordic
// Pipelined rotation CORDIC: one iteration per stage, then quadrant fold-out.
// Carries the clamped command alongside the angle.
// ----------------------------------------------------------------------------
module spm_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [spm_pkg::U2_W-1:0]       in_u2,
  input  logic        [spm_pkg::TURN_W-1:0]     in_turn,
  output logic                                  out_valid,
  output logic signed [spm_pkg::U2_W-1:0]       out_u2,
  output logic signed [spm_pkg::TRIG_W-1:0]     out_sin,
  output logic signed [spm_pkg::TRIG_W-1:0]     out_cos
);
  import spm_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [CORD_W-1:0] x_p   [N+1];
  logic signed [CORD_W-1:0] y_p   [N+1];
  logic signed [TURN_W-1:0] z_p   [N+1];
  logic        [1:0]        quad_p[N+1];
  logic signed [U2_W-1:0]   u2_p  [N+1];
  logic                     vld_p [N+1];

  // load stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p[0] <= 1'b0;
    end else begin
      vld_p[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_p[0]    <= CORDIC_GAIN_Q30;
    y_p[0]    <= '0;
    z_p[0]    <= $signed({2'b00, in_turn[TURN_W-3:0]});
    quad_p[0] <= in_turn[TURN_W-1:TURN_W-2];
    u2_p[0]   <= in_u2;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    localparam logic signed [TURN_W-1:0] ATAN = atan_turn(i);

    assign dx = y_p[i] >>> i;
    assign dy = x_p[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_p[i+1] <= 1'b0;
      end else begin
        vld_p[i+1] <= vld_p[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!z_p[i][TURN_W-1]) begin
        x_p[i+1] <= x_p[i] - dx;
        y_p[i+1] <= y_p[i] + dy;
        z_p[i+1] <= z_p[i] - ATAN;
      end else begin
        x_p[i+1] <= x_p[i] + dx;
        y_p[i+1] <= y_p[i] - dy;
        z_p[i+1] <= z_p[i] + ATAN;
      end
      quad_p[i+1] <= quad_p[i];
      u2_p[i+1]   <= u2_p[i];
    end
  end

  // rotate the first-quadrant result into the angle's quadrant
  logic signed [CORD_W-1:0] xf;
  logic signed [CORD_W-1:0] yf;
  assign xf = x_p[N];
  assign yf = y_p[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_p[N];
    end
  end

  always_ff @(posedge clk) begin
    out_u2 <= u2_p[N];
    case (quad_p[N])
      2'd0: begin
        out_cos <= TRIG_W'(xf);
        out_sin <= TRIG_W'(yf);
      end
      2'd1: begin
        out_cos <= TRIG_W'(-yf);
        out_sin <= TRIG_W'(xf);
      end
      2'd2: begin
        out_cos <= TRIG_W'(-xf);
        out_sin <= TRIG_W'(-yf);
      end
      default: begin
        out_cos <= TRIG_W'(yf);
        out_sin <= TRIG_W'(-xf);
      end
    endcase
  end

endmodule

FILE: rtl/core/spm_mix.sv
// ----------------------------------------------------------------------------
// spm_mix
// Inverse Park and inverse Clarke in three stages: products, scale by sqrt(3),
// phase sums with the half-supply offset.
// ----------------------------------------------------------------------------
module spm_mix (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [spm_pkg::SUPPLY_W-1:0]          supply,
  input  logic                                  in_valid,
  input  logic signed [spm_pkg::U2_W-1:0]       in_u2,
  input  logic signed [spm_pkg::TRIG_W-1:0]     in_sin,
  input  logic signed [spm_pkg::TRIG_W-1:0]     in_cos,
  output logic                                  out_valid,
  output spm_pkg::phase_vec_t                   out_volt
);
  import spm_pkg::*;

  localparam int PW = U2_W + TRIG_W;   // product width
  localparam int AW = PW + 1 - 14;     // alpha after the shift
  localparam int BW = PW - 14;         // beta after the shift
  localparam int MW = BW + U2_W;       // beta * sqrt(3)

  logic              vld1, vld2;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [AW-1:0] alpha;
  logic signed [MW-1:0] beta_r3;

  logic signed [PW:0]   neg_a;
  logic signed [BW-1:0] beta;
  assign neg_a = -((PW+1)'(prod_a));
  assign beta  = BW'(prod_b >>> 14);

  logic signed [VOLT_W-1:0] sb, al, mid, diff_b, diff_c;
  assign sb     = VOLT_W'(beta_r3 >>> 16);
  assign al     = VOLT_W'(alpha);
  assign mid    = $signed(VOLT_W'({supply, 16'b0}));
  assign diff_b = sb - al;
  assign diff_c = -al - sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    prod_a      <= PW'(in_u2 * in_sin);
    prod_b      <= PW'(in_u2 * in_cos);
    alpha       <= AW'(neg_a >>> 14);
    beta_r3     <= MW'(SQRT3_Q16 * beta);
    out_volt[0] <= al + mid;
    out_volt[1] <= (diff_b >>> 1) + mid;
    out_volt[2] <= (diff_c >>> 1) + mid;
  end

endmodule

FILE: rtl/core/spm_div.sv
// ----------------------------------------------------------------------------
// spm_div
// Duty computation for three phases: clamp to 0..full scale, then a restoring
// divider with one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module spm_div #(
  parameter int DUTY_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [spm_pkg::SUPPLY_W-1:0]          supply,
  input  logic                                  in_valid,
  input  spm_pkg::phase_vec_t                   in_volt,
  output logic                                  out_valid,
  output logic [spm_pkg::DUTY_OUT_W-1:0]        out_duty [3]
);
  import spm_pkg::*;

  localparam int DB = DUTY_BITS;
  localparam logic [DB-1:0] DUTY_TOP = '1;

  logic [FULL_W-1:0] full;
  logic signed [VOLT_W-1:0] full_s;
  assign full   = {supply, 17'b0};
  assign full_s = $signed(VOLT_W'(full));

  logic [FULL_W-1:0] rem [DB+1][3];
  logic [DB-1:0]     quo [DB+1][3];
  logic              sat [DB+1][3];
  logic              vld [DB+1];

  // clamp stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      quo[0][l] <= '0;
      if (in_volt[l] < 0) begin
        rem[0][l] <= '0;
        sat[0][l] <= (full == '0);
      end else if (in_volt[l] >= full_s) begin
        rem[0][l] <= '0;
        sat[0][l] <= 1'b1;
      end else begin
        rem[0][l] <= FULL_W'(in_volt[l]);
        sat[0][l] <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < DB; k++) begin : g_step
    logic [FULL_W:0] trial [3];
    logic            fits  [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem[k][l], 1'b0};
        fits[l]  = (trial[l] >= {1'b0, full});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 3; l++) begin
        rem[k+1][l] <= fits[l] ? FULL_W'(trial[l] - {1'b0, full}) : FULL_W'(trial[l]);
        quo[k+1][l] <= {quo[k][l][DB-2:0], fits[l]};
        sat[k+1][l] <= sat[k][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[DB];
    end
  end

  // zero supply forces zero duty
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (supply == '0) begin
        out_duty[l] <= '0;
      end else if (sat[DB][l]) begin
        out_duty[l] <= DUTY_OUT_W'(DUTY_TOP);
      end else begin
        out_duty[l] <= DUTY_OUT_W'(quo[DB][l]);
      end
    end
  end

endmodule

FILE: rtl/core/sine_pwm_phase_modulator.sv
// ----------------------------------------------------------------------------
// sine_pwm_phase_modulator
// Sinusoidal PWM: clamps a q-axis command, applies inverse Park and inverse
// Clarke, and gives three phase duty cycles.
// ----------------------------------------------------------------------------
// The block takes one item per clock and never raises busy; the receiver
// cannot stall and none is needed. An item accepted on start appears on
// duty_a/b/c with done after passing the CORDIC sine/cosine (one stage per
// iteration plus load and quadrant stages), the multiply and phase mixing
// stages, and the bit-per-stage duty divider with its clamp and output
// stages. Write cfg_wdata with cfg_wen only while no item is in flight.
// ----------------------------------------------------------------------------
module sine_pwm_phase_modulator #(
  parameter int ANGLE_BITS = 16,
  parameter int DUTY_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [spm_pkg::SUPPLY_W-1:0]          cfg_wdata,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [spm_pkg::CMD_W-1:0]      quad_voltage,
  input  logic [spm_pkg::ANG_IN_W-1:0]          elec_angle,
  output logic                                  done,
  output logic [spm_pkg::DUTY_OUT_W-1:0]        duty_a,
  output logic [spm_pkg::DUTY_OUT_W-1:0]        duty_b,
  output logic [spm_pkg::DUTY_OUT_W-1:0]        duty_c
);
  import spm_pkg::*;

  logic [SUPPLY_W-1:0] supply;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply <= SUPPLY_W'(12000);
    end else if (cfg_wen) begin
      supply <= cfg_wdata;
    end
  end

  // pipeline always flows
  assign busy = 1'b0;

  // double the command into half-mV and clamp to +/- supply
  logic signed [U2_W-1:0] u2_raw, s_pos, s_neg, u2;
  assign u2_raw = U2_W'(quad_voltage) <<< 1;
  assign s_pos  = $signed(U2_W'(supply));
  assign s_neg  = -s_pos;

  always_comb begin
    if (u2_raw > s_pos) begin
      u2 = s_pos;
    end else if (u2_raw < s_neg) begin
      u2 = s_neg;
    end else begin
      u2 = u2_raw;
    end
  end

  // high angle bits beyond ANGLE_BITS fall off the top
  logic [TURN_W-1:0] turn;
  assign turn = TURN_W'(TURN_W'(elec_angle) << (TURN_W - ANGLE_BITS));

  logic                      cord_valid;
  logic signed [U2_W-1:0]    cord_u2;
  logic signed [TRIG_W-1:0]  cord_sin, cord_cos;

  spm_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_u2     (u2),
    .in_turn   (turn),
    .out_valid (cord_valid),
    .out_u2    (cord_u2),
    .out_sin   (cord_sin),
    .out_cos   (cord_cos)
  );

  logic       mix_valid;
  phase_vec_t mix_volt;

  spm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .supply    (supply),
    .in_valid  (cord_valid),
    .in_u2     (cord_u2),
    .in_sin    (cord_sin),
    .in_cos    (cord_cos),
    .out_valid (mix_valid),
    .out_volt  (mix_volt)
  );

  logic [DUTY_OUT_W-1:0] duty [3];

  spm_div #(
    .DUTY_BITS (DUTY_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .supply    (supply),
    .in_valid  (mix_valid),
    .in_volt   (mix_volt),
    .out_valid (done),
    .out_duty  (duty)
  );

  assign duty_a = duty[0];
  assign duty_b = duty[1];
  assign duty_c = duty[2];

endmodule
